@@ design/hbm_pkg.sv @@
// Shared types and constants for the multi-source heartbeat monitor.
// No dependencies; used by hbm_table, hbm_ctrl and the top level.
package hbm_pkg;

    localparam int SOURCES_DEF = 12;
    localparam int TIME_W      = 32;
    localparam int SRC_W       = 8;
    localparam int FAULT_W     = 6;
    localparam int TMO_W       = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd10;

    localparam logic KIND_BEAT = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        logic              fault;
        logic [TIME_W-1:0] last;
    } entry_t;

endpackage

@@ design/hbm_table.sv @@
// Per-source state memory: last-seen time and fault mark, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on hbm_pkg.
module hbm_table #(
    parameter int SOURCES = hbm_pkg::SOURCES_DEF,
    parameter int IDX_W   = $clog2(SOURCES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output hbm_pkg::entry_t     rd_entry,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  hbm_pkg::entry_t     wr_entry
);

    hbm_pkg::entry_t mem [SOURCES];
    hbm_pkg::entry_t rd_data_reg;
    logic            rd_valid_reg;
    logic [SOURCES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/hbm_ctrl.sv @@
// Beat handling, scan sequencer and result register for the heartbeat monitor.
// Drives the hbm_table ports; holds the timeout register. Depends on hbm_pkg.
module hbm_ctrl #(
    parameter int SOURCES = hbm_pkg::SOURCES_DEF,
    parameter int IDX_W   = $clog2(SOURCES)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [71:0]                 s_tdata,
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hbm_pkg::FAULT_W-1:0] m_fault_source,
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hbm_pkg::TMO_W-1:0]   cfg_data,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_idx,
    input  hbm_pkg::entry_t             rd_entry,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_idx,
    output hbm_pkg::entry_t             wr_entry
);

    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SOURCES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            addr_reg, addr_next;
    logic                        eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]            eval_idx_reg, eval_idx_next;
    logic [hbm_pkg::TIME_W-1:0]  now_reg, now_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [hbm_pkg::FAULT_W-1:0] out_src_reg, out_src_next;
    logic                        out_last_reg, out_last_next;
    logic [hbm_pkg::TMO_W-1:0]   timeout_reg;

    logic [hbm_pkg::SRC_W-1:0]   in_src;
    logic [hbm_pkg::TIME_W-1:0]  in_stamp;
    logic [hbm_pkg::TIME_W-1:0]  in_now;
    logic [hbm_pkg::TIME_W-1:0]  elapsed;
    logic                        hit;
    logic                        out_free;
    logic                        stall;
    logic                        more;

    assign in_src   = s_tdata[7:0];
    assign in_stamp = s_tdata[39:8];
    assign in_now   = s_tdata[71:40];

    assign elapsed  = now_reg - rd_entry.last;
    assign hit      = eval_valid_reg && (rd_entry.last != '0) && !rd_entry.fault
                      && (elapsed >= {{(hbm_pkg::TIME_W-hbm_pkg::TMO_W){1'b0}}, timeout_reg});
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = hit && pend_valid_reg && !out_free;
    assign more     = addr_reg < CNT_END;

    assign s_tready       = (state_reg == ST_IDLE);
    assign cfg_ready      = (state_reg == ST_IDLE);
    assign m_tvalid       = out_valid_reg;
    assign m_fault_source = out_src_reg;
    assign m_tlast        = out_last_reg;
    assign rd_idx         = addr_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_src_next    = out_src_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = eval_idx_reg;
        wr_entry        = '{fault: 1'b1, last: rd_entry.last};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == hbm_pkg::KIND_SCAN) begin
                        now_next        = in_now;
                        addr_next       = CNT_W'(1);
                        eval_valid_next = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end else if (in_src < hbm_pkg::SRC_W'(SOURCES)) begin
                        wr_en    = 1'b1;
                        wr_idx   = in_src[IDX_W-1:0];
                        wr_entry = '{fault: 1'b0,
                                     last: (in_stamp != '0) ? in_stamp : in_now};
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    rd_en           = more;
                    eval_valid_next = more;
                    eval_idx_next   = addr_reg[IDX_W-1:0];
                    if (more) begin
                        addr_next = addr_reg + CNT_W'(1);
                    end
                    if (hit) begin
                        wr_en = 1'b1;
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_src_next   = hbm_pkg::FAULT_W'(pend_idx_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = eval_idx_reg;
                    end
                    if (!more && !eval_valid_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_src_next    = hbm_pkg::FAULT_W'(pend_idx_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= hbm_pkg::TIMEOUT_RST;
        end else begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        eval_idx_reg <= eval_idx_next;
        now_reg      <= now_next;
        pend_idx_reg <= pend_idx_next;
        out_src_reg  <= out_src_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ design/multi_source_heartbeat_monitor_top.sv @@
// Heartbeat monitor over SOURCES sources: per-source last-seen time and fault mark.
// Input beat: tuser = kind (0 heartbeat, 1 scan); tdata = source_id, stamp, now.
// A heartbeat beat stores its time (stamp, or now when stamp is zero) and clears
// the fault mark of its source; ids at or above SOURCES are dropped, and s_tready
// stays high. A scan beat walks sources 1 to SOURCES-1 through the state memory,
// one entry per cycle while the scan is not paused, with the read of the next
// entry overlapping the check of the current one; s_tready is low after a scan
// beat until the scan has ended and any held fault has gone to the output
// register. Each newly overdue source gives one output
// beat (m_tdata = fault source); the final one of a scan has m_tlast set. One
// fault is held back until the next one or the end of the scan is found, so an
// output beat can trail its check by up to the rest of the scan.
// When m_tready is low the output register holds its beat; the scan pauses when
// it finds a fault while the held fault is full and the output beat is not taken.
// The timeout register is written through cfg_valid/cfg_ready/cfg_data, only
// while idle; reset loads 10. Reset clears all entries to never seen and
// unfaulted at once (per-entry valid bits) and drops any result in flight.
module multi_source_heartbeat_monitor_top #(
    parameter int SOURCES = hbm_pkg::SOURCES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // source_id[7:0], stamp[39:8], now_seconds[71:40]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // fault_source[5:0], zero[7:6]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(SOURCES);

    logic                        rd_en;
    logic [IDX_W-1:0]            rd_idx;
    hbm_pkg::entry_t             rd_entry;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;
    hbm_pkg::entry_t             wr_entry;
    logic [hbm_pkg::FAULT_W-1:0] fault_source;

    hbm_table #(
        .SOURCES (SOURCES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    hbm_ctrl #(
        .SOURCES (SOURCES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_fault_source (fault_source),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .rd_en          (rd_en),
        .rd_idx         (rd_idx),
        .rd_entry       (rd_entry),
        .wr_en          (wr_en),
        .wr_idx         (wr_idx),
        .wr_entry       (wr_entry)
    );

    assign m_tdata = {2'b00, fault_source};

    a_beat_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == hbm_pkg::KIND_BEAT) |=> s_tready)
        else $error("heartbeat beat blocked the input");

    a_scan_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == hbm_pkg::KIND_SCAN) |=> !s_tready)
        else $error("scan did not start");

    a_fault_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (fault_source != '0) && (32'(fault_source) < 32'(SOURCES)))
        else $error("fault source out of range");

    a_no_write_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !s_tready) |-> wr_entry.fault)
        else $error("scan wrote an entry without setting its fault mark");

endmodule

@@ test/tb.sv @@
// Testbench for multi_source_heartbeat_monitor_top: drives heartbeat and scan beats
// and checks every fault beat against a predictor of the per-source table.
// Depends on hbm_pkg and the RTL under design/ only.
module tb;

    localparam int NSRC      = hbm_pkg::SOURCES_DEF;
    localparam int PERIOD    = 12;
    localparam int SCAN_TAIL = NSRC + 12;
    localparam int PHASE_LEN = 48;

    typedef struct {
        logic                       kind;
        logic [hbm_pkg::SRC_W-1:0]  src;
        logic [hbm_pkg::TIME_W-1:0] stamp;
        logic [hbm_pkg::TIME_W-1:0] now;
    } hb_item_t;

    typedef struct {
        logic [hbm_pkg::FAULT_W-1:0] src;
        logic                        last;
    } fault_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // source_id[7:0], stamp[39:8], now_seconds[71:40]
    logic        s_tuser = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // fault_source[5:0], zero[7:6]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    hb_item_t                   beat_q[$];
    fault_t                     fault_q[$];
    logic [hbm_pkg::TIME_W-1:0] seen_time [NSRC];
    logic                       faulted [NSRC];
    logic [hbm_pkg::TMO_W-1:0]  tmo_now = hbm_pkg::TIMEOUT_RST;

    logic in_taken = 1'b0, out_taken = 1'b0, cfg_taken = 1'b0;
    logic rx_hold = 1'b0, squeeze_go = 1'b0;
    logic tx_burst = 1'b0, rx_burst = 1'b0;
    int   tx_gap = 0, rx_wait = 0;
    int   n_queued = 0, n_accepted = 0, mismatches = 0;
    int   n_beats = 0, n_ignored = 0, n_scans = 0, n_faults = 0;
    logic [hbm_pkg::TIME_W-1:0] uptime;

    multi_source_heartbeat_monitor_top #(.SOURCES(NSRC)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    initial begin
        for (int i = 0; i < NSRC; i++) begin
            seen_time[i] = '0;
            faulted[i] = 1'b0;
        end
    end

    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= 10;
    endfunction

    function automatic void predict_faults(input hb_item_t it);
        logic [hbm_pkg::TIME_W-1:0] elapsed;
        int                         found;
        found = 0;
        if (it.kind == hbm_pkg::KIND_BEAT) begin
            n_beats++;
            if (it.src < NSRC) begin
                seen_time[it.src] = (it.stamp != '0) ? it.stamp : it.now;
                faulted[it.src] = 1'b0;
            end else begin
                n_ignored++;
            end
        end else begin
            n_scans++;
            for (int i = 1; i < NSRC; i++) begin
                elapsed = it.now - seen_time[i];
                if (seen_time[i] != '0 && !faulted[i]
                    && elapsed >= hbm_pkg::TIME_W'(tmo_now)) begin
                    faulted[i] = 1'b1;
                    fault_q.push_back('{src: hbm_pkg::FAULT_W'(i), last: 1'b0});
                    found++;
                end
            end
            if (found > 0)
                fault_q[fault_q.size() - 1].last = 1'b1;
        end
    endfunction

    // monitor: sample all handshakes at the rising edge
    always @(posedge aclk) begin
        hb_item_t it;
        fault_t   f;
        in_taken  <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (aresetn && m_tvalid && m_tready) begin
            n_faults++;
            if (fault_q.size() == 0) begin
                if (count_mismatch())
                    $display("unexpected fault beat: tdata %h last %b", m_tdata, m_tlast);
            end else begin
                f = fault_q.pop_front();
                if (m_tdata !== {2'b00, f.src} || m_tlast !== f.last) begin
                    if (count_mismatch())
                        $display({"fault beat mismatch: expected src %0d last %b, ",
                                  "got tdata %h last %b"},
                                 f.src, f.last, m_tdata, m_tlast);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            it.kind  = s_tuser;
            it.src   = s_tdata[7:0];
            it.stamp = s_tdata[39:8];
            it.now   = s_tdata[71:40];
            predict_faults(it);
            n_accepted++;
        end
        if (aresetn && cfg_valid && cfg_ready)
            tmo_now = cfg_data;
    end

    // driver: hold a beat until taken, then idle for the drawn gap
    always @(negedge aclk) begin
        hb_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (tx_gap > 0) begin
            s_tvalid <= 1'b0;
            tx_gap--;
        end else if (beat_q.size() > 0) begin
            it = beat_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= it.kind;
            s_tdata  <= {it.now, it.stamp, it.src};
            tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                tx_burst = !tx_burst;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: stall a drawn number of cycles after each fault beat, and while rx_hold is set
    always @(negedge aclk) begin
        if (out_taken) begin
            rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
        end
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        wait (squeeze_go);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (400) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #(PERIOD * 300000);
        $display("TEST FAILED");
        $finish;
    end

    task automatic queue_beat(input logic kind, input logic [hbm_pkg::SRC_W-1:0] src,
                              input logic [hbm_pkg::TIME_W-1:0] stamp,
                              input logic [hbm_pkg::TIME_W-1:0] now);
        beat_q.push_back('{kind: kind, src: src, stamp: stamp, now: now});
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || fault_q.size() != 0)
            @(negedge aclk);
        repeat (SCAN_TAIL) @(negedge aclk);
    endtask

    task automatic write_timeout(input logic [hbm_pkg::TMO_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int tmo, input int count);
        int unsigned               span;
        logic [hbm_pkg::SRC_W-1:0] src;
        span = tmo + tmo / 2 + 2;
        uptime = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4 * span)
                                             : $urandom;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 2) begin
                queue_beat(1'($urandom_range(0, 1)),
                           hbm_pkg::SRC_W'($urandom_range(0, 255)),
                           ($urandom_range(0, 3) == 0) ? '0 : $urandom, $urandom);
            end else if ($urandom_range(0, 9) < 3) begin
                uptime += $urandom_range(0, span);
                queue_beat(hbm_pkg::KIND_SCAN, hbm_pkg::SRC_W'($urandom_range(0, 255)),
                           $urandom, uptime);
            end else begin
                src = ($urandom_range(0, 15) == 0) ? '0
                      : hbm_pkg::SRC_W'($urandom_range(1, NSRC - 1));
                queue_beat(hbm_pkg::KIND_BEAT, src,
                           ($urandom_range(0, 3) == 0) ? '0 : uptime - $urandom_range(0, span),
                           uptime);
            end
        end
    endtask

    initial begin
        int tmo_list [6];
        tmo_list = '{1, 0, 65535, 37, 0, 10};
        tmo_list[4] = $urandom_range(2, 500);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        queue_beat(hbm_pkg::KIND_SCAN, 8'd0, 32'd0, 32'd50);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd0, 32'd5, 32'd0);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd12, 32'd100, 32'd0);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd255, 32'd7, 32'hFFFF_FFFF);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd1, 32'd0, 32'd0);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd1, 32'd0, 32'd1000);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd11, 32'hFFFF_FFFF, 32'd0);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd2, 32'd995, 32'd0);
        queue_beat(hbm_pkg::KIND_SCAN, 8'd0, 32'd0, 32'd1005);
        queue_beat(hbm_pkg::KIND_SCAN, 8'd0, 32'd0, 32'd1005);
        queue_beat(hbm_pkg::KIND_BEAT, 8'd2, 32'd0, 32'd1010);
        queue_beat(hbm_pkg::KIND_SCAN, 8'd0, 32'd0, 32'd1009);
        for (int i = 1; i < NSRC; i++)
            queue_beat(hbm_pkg::KIND_BEAT, i[hbm_pkg::SRC_W-1:0], 32'd1, 32'd0);
        queue_beat(hbm_pkg::KIND_SCAN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        foreach (tmo_list[p]) begin
            write_timeout(tmo_list[p][hbm_pkg::TMO_W-1:0]);
            if (p == 3)
                squeeze_go = 1'b1;
            run_phase(tmo_list[p], PHASE_LEN);
            wait_idle();
        end

        $display("covered %0d beats: %0d heartbeats (%0d out of range), %0d scans",
                 n_accepted, n_beats, n_ignored, n_scans);
        $display("checked %0d fault beats over timeouts 10, 0, 1, 65535 and others",
                 n_faults);
        if (mismatches == 0 && fault_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
